/* hdl/srr_pkg.sv */
`default_nettype none

package srr_pkg;

    // field widths of the packet and result beats
    localparam int SEQ_W = 8;
    localparam int TAG_W = 64;
    localparam int LEN_W = 10;

    // protocol constants
    localparam int SEQ_SPACE   = 256;
    localparam int PAYLOAD_MAX = 1004;
    localparam int WINDOW_DEF  = 8;

    // expected-sequence register and shared modular adder widths
    localparam int EXP_W = $clog2(SEQ_SPACE);
    localparam int ALU_W = EXP_W + 1;

    // result kind codes
    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OFFSET,
        ST_SLOT,
        ST_ACK,
        ST_DR_SEQ,
        ST_DR_SLOT,
        ST_DR_EMIT
    } srr_state_t;

    // operand selection for the shared modular adder
    typedef enum logic [1:0] {
        ALU_OFFSET,
        ALU_SLOT,
        ALU_NEXT_SEQ,
        ALU_NEXT_SLOT
    } srr_alu_sel_t;

endpackage

`default_nettype wire

/* hdl/srr_modadd.sv */
`default_nettype none

// (a + b) mod m, for a < m and b <= m
module srr_modadd #(
    parameter int W = srr_pkg::ALU_W
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic [W-1:0] m,
    output logic      [W-1:0] r
);
    import srr_pkg::*;

    logic [W:0] sum;
    logic [W:0] m_ext;

    // add, then fold once
    always_comb
    begin
        sum   = {1'b0, a} + {1'b0, b};
        m_ext = {1'b0, m};
        if (sum >= m_ext)
        begin
            r = W'(sum - m_ext);
        end
        else
        begin
            r = W'(sum);
        end
    end

endmodule

`default_nettype wire

/* hdl/srr_slot_mem.sv */
`default_nettype none

// reorder slot storage: one write port, one registered read port
module srr_slot_mem #(
    parameter int DEPTH = srr_pkg::WINDOW_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [srr_pkg::TAG_W-1:0]  wr_tag,
    input  wire logic [srr_pkg::LEN_W-1:0]  wr_len,
    input  wire logic [AW-1:0]              rd_addr,
    output logic      [srr_pkg::TAG_W-1:0]  rd_tag,
    output logic      [srr_pkg::LEN_W-1:0]  rd_len
);
    import srr_pkg::*;

    logic [TAG_W-1:0] tag_mem [DEPTH];
    logic [LEN_W-1:0] len_mem [DEPTH];

    // write stored packet
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[wr_addr] <= wr_tag;
            len_mem[wr_addr] <= wr_len;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_tag <= tag_mem[rd_addr];
        rd_len <= len_mem[rd_addr];
    end

endmodule

`default_nettype wire

/* hdl/selective_repeat_receive_reorder_top.sv */
`default_nettype none

// Sequence: a packet that is only acknowledged passes the accept, offset, slot and ack steps;
// each in-order delivery adds the next sequence, next slot and emit steps, and output stalls
// can hold the ack and emit steps until the output beat is taken.
// Throughput: one packet at a time; the shared modular adder is used once per step.
// Reset (rst_n low, asynchronous): expected sequence, slot head, done flag, marks and
// handshake state clear at once; slot contents are left undefined.
module selective_repeat_receive_reorder_top #(
    parameter int WINDOW = srr_pkg::WINDOW_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [srr_pkg::SEQ_W-1:0]  seq_num,
    input  wire logic [srr_pkg::TAG_W-1:0]  payload_tag,
    input  wire logic [srr_pkg::LEN_W-1:0]  payload_len,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            kind,
    output logic      [srr_pkg::SEQ_W-1:0]  out_seq,
    output logic      [srr_pkg::TAG_W-1:0]  out_tag,
    output logic      [srr_pkg::LEN_W-1:0]  out_len,
    output logic                            transfer_end,
    output logic                            last
);
    import srr_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [ALU_W-1:0]  SPACE_A = ALU_W'(SEQ_SPACE);
    localparam logic [ALU_W-1:0]  WIN_A   = ALU_W'(WINDOW);
    localparam logic [SLOT_W-1:0] CNT_MAX = SLOT_W'(WINDOW - 1);

    srr_state_t state_reg, state_next;

    // captured packet
    logic [SEQ_W-1:0] seq_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [LEN_W-1:0] len_reg;

    // receiver state
    logic [EXP_W-1:0]  expected_reg;
    logic [SLOT_W-1:0] head_reg;
    logic              done_reg;
    logic [WINDOW-1:0] mark_reg;

    // sequencer working registers
    logic [ALU_W-1:0]  off_reg;
    logic              drain_reg;
    logic [SLOT_W-1:0] cnt_reg;
    logic [EXP_W-1:0]  nseq_reg;
    logic [SLOT_W-1:0] nslot_reg;

    // output register
    logic              out_valid_reg;
    logic              kind_reg;
    logic [SEQ_W-1:0]  oseq_reg;
    logic [TAG_W-1:0]  otag_reg;
    logic [LEN_W-1:0]  olen_reg;
    logic              oend_reg;
    logic              olast_reg;

    // shared adder
    srr_alu_sel_t     alu_sel;
    logic [ALU_W-1:0] alu_a, alu_b, alu_m, alu_r;

    // control strobes
    logic emit_ok;
    logic accept;
    logic ld_off, ld_slot, ld_ack, ld_nseq, ld_nslot, ld_del;

    // decisions
    logic [SLOT_W-1:0] slot_now;
    logic              store_ok;
    logic              short_pkt;
    logic              del_last;

    // slot memory read data
    logic [TAG_W-1:0] rd_tag;
    logic [LEN_W-1:0] rd_len;

    // operand select for the shared adder
    always_comb
    begin
        case (alu_sel)
            ALU_OFFSET:
            begin
                alu_a = ALU_W'(seq_reg);
                alu_b = SPACE_A - ALU_W'(expected_reg);
                alu_m = SPACE_A;
            end
            ALU_SLOT:
            begin
                alu_a = ALU_W'(head_reg);
                alu_b = off_reg;
                alu_m = WIN_A;
            end
            ALU_NEXT_SEQ:
            begin
                alu_a = ALU_W'(expected_reg);
                alu_b = ALU_W'(1);
                alu_m = SPACE_A;
            end
            default:
            begin
                alu_a = ALU_W'(head_reg);
                alu_b = ALU_W'(1);
                alu_m = WIN_A;
            end
        endcase
    end

    srr_modadd #(
        .W (ALU_W)
    ) u_modadd (
        .a (alu_a),
        .b (alu_b),
        .m (alu_m),
        .r (alu_r)
    );

    srr_slot_mem #(
        .DEPTH (WINDOW),
        .AW    (SLOT_W)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (ld_slot && store_ok),
        .wr_addr (slot_now),
        .wr_tag  (tag_reg),
        .wr_len  (len_reg),
        .rd_addr (head_reg),
        .rd_tag  (rd_tag),
        .rd_len  (rd_len)
    );

    // store decision: in window, transfer open, slot not yet marked
    always_comb
    begin
        slot_now = alu_r[SLOT_W-1:0];
        store_ok = 1'b0;
        if (!done_reg && (int'(seq_reg) < SEQ_SPACE) && (off_reg < WIN_A))
        begin
            store_ok = !mark_reg[slot_now];
        end
    end

    // delivery decision: stop at a short packet, a full window, or a gap
    always_comb
    begin
        short_pkt = int'(rd_len) < PAYLOAD_MAX;
        del_last  = short_pkt || (cnt_reg == CNT_MAX) || !mark_reg[nslot_reg];
    end

    assign emit_ok = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_OFFSET;
                end
            end
            ST_OFFSET:
            begin
                state_next = ST_SLOT;
            end
            ST_SLOT:
            begin
                state_next = ST_ACK;
            end
            ST_ACK:
            begin
                if (emit_ok)
                begin
                    state_next = drain_reg ? ST_DR_SEQ : ST_IDLE;
                end
            end
            ST_DR_SEQ:
            begin
                state_next = ST_DR_SLOT;
            end
            ST_DR_SLOT:
            begin
                state_next = ST_DR_EMIT;
            end
            ST_DR_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = del_last ? ST_IDLE : ST_DR_SEQ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        ld_off   = 1'b0;
        ld_slot  = 1'b0;
        ld_ack   = 1'b0;
        ld_nseq  = 1'b0;
        ld_nslot = 1'b0;
        ld_del   = 1'b0;
        alu_sel  = ALU_OFFSET;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_OFFSET:
            begin
                alu_sel = ALU_OFFSET;
                ld_off  = 1'b1;
            end
            ST_SLOT:
            begin
                alu_sel = ALU_SLOT;
                ld_slot = 1'b1;
            end
            ST_ACK:
            begin
                ld_ack = emit_ok;
            end
            ST_DR_SEQ:
            begin
                alu_sel = ALU_NEXT_SEQ;
                ld_nseq = 1'b1;
            end
            ST_DR_SLOT:
            begin
                alu_sel  = ALU_NEXT_SLOT;
                ld_nslot = 1'b1;
            end
            ST_DR_EMIT:
            begin
                alu_sel = ALU_NEXT_SLOT;
                ld_del  = emit_ok;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // capture packet
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            seq_reg <= seq_num;
            tag_reg <= payload_tag;
            len_reg <= payload_len;
        end
    end

    // hold working values of the sequencer
    always_ff @(posedge clk)
    begin
        if (ld_off)
        begin
            off_reg <= alu_r;
        end
        if (ld_nseq)
        begin
            nseq_reg <= alu_r[EXP_W-1:0];
        end
        if (ld_nslot)
        begin
            nslot_reg <= alu_r[SLOT_W-1:0];
        end
    end

    // receiver state: marks, window position, done flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= '0;
            head_reg     <= '0;
            done_reg     <= 1'b0;
            mark_reg     <= '0;
            drain_reg    <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg <= '0;
            end
            if (ld_slot)
            begin
                drain_reg <= store_ok && (off_reg == '0);
                if (store_ok)
                begin
                    mark_reg[slot_now] <= 1'b1;
                end
            end
            if (ld_del)
            begin
                mark_reg[head_reg] <= 1'b0;
                expected_reg       <= nseq_reg;
                head_reg           <= nslot_reg;
                cnt_reg            <= cnt_reg + SLOT_W'(1);
                if (short_pkt)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // output valid: set on load, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ld_ack || ld_del)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (ld_ack)
        begin
            kind_reg  <= KIND_ACK;
            oseq_reg  <= seq_reg;
            otag_reg  <= '0;
            olen_reg  <= '0;
            oend_reg  <= 1'b0;
            olast_reg <= !drain_reg;
        end
        else if (ld_del)
        begin
            kind_reg  <= KIND_DELIVER;
            oseq_reg  <= SEQ_W'(expected_reg);
            otag_reg  <= rd_tag;
            olen_reg  <= rd_len;
            oend_reg  <= short_pkt;
            olast_reg <= del_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign out_seq      = oseq_reg;
    assign out_tag      = otag_reg;
    assign out_len      = olen_reg;
    assign transfer_end = oend_reg;
    assign last         = olast_reg;

endmodule

`default_nettype wire
